### rtl/axis_angle_rotation_matrix_top_defines.svh
// assertion helpers shared by the checker
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_DEFINES_SVH
`define AARM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AARM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/aarm_pkg.sv
package aarm_pkg;
	localparam int MaxSteps = 30;
	localparam int FracBits = 30;
	localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
	localparam logic signed [15:0] PiQ13 = 16'sd25736;
	localparam logic signed [15:0] OneQ14 = 16'sd16384;
	localparam longint GainInf = 652032874;
	localparam longint GainCorr = 434688583;

	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} out_item_t;

	// atan(2^-i), 30 fractional bits
	function automatic logic signed [33:0] atan_lut(input int i);
		case (i)
			0: atan_lut = 34'sd843314857;
			1: atan_lut = 34'sd497837829;
			2: atan_lut = 34'sd263043837;
			3: atan_lut = 34'sd133525159;
			4: atan_lut = 34'sd67021687;
			5: atan_lut = 34'sd33543516;
			6: atan_lut = 34'sd16775851;
			7: atan_lut = 34'sd8388437;
			8: atan_lut = 34'sd4194283;
			9: atan_lut = 34'sd2097149;
			default: atan_lut = (i < MaxSteps) ? 34'sd1 <<< (FracBits - i) : 34'sd0;
		endcase
	endfunction

	function automatic logic [15:0] sat_round(input logic signed [47:0] v);
		logic signed [47:0] r;
		r = (v + 48'sd134217728) >>> 28;
		if (r > 48'sd16384)
			sat_round = 16'sd16384;
		else if (r < -48'sd16384)
			sat_round = -16'sd16384;
		else
			sat_round = r[15:0];
	endfunction
endpackage

### rtl/axis_angle_rotation_matrix_top.sv
// channel | signals                      | payload
// in      | in_valid / in_ready / in_data  | in_item_t
// out     | out_valid / out_ready / out_data | out_item_t
// One item per cycle while out is not stalled, set by the
// pipeline of one CORDIC micro-rotation per stage.
// Reset clears only the valid bits. A stall on out holds the whole pipeline
// (global enable); in_ready = out_ready or output register empty.
module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic en;
	assign en = out_ready || !out_valid;
	assign in_ready = en;

	// quadrant fold
	logic v_s1, f_s1;
	logic signed [15:0] a_s1;
	logic [47:0] ax_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= (in_data.angle > HalfPiQ13) || (in_data.angle < -HalfPiQ13);
			if (in_data.angle > HalfPiQ13)
				a_s1 <= in_data.angle - PiQ13;
			else if (in_data.angle < -HalfPiQ13)
				a_s1 <= in_data.angle + PiQ13;
			else
				a_s1 <= in_data.angle;
			ax_s1 <= {in_data.axis_x, in_data.axis_y, in_data.axis_z};
		end
	end

	logic vc, fc;
	logic signed [15:0] cc, sc;
	logic [47:0] axc;
	aarm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s1), .flip_in(f_s1),
		.ang_in(a_s1), .tag_in(ax_s1), .vld_out(vc), .flip_out(fc),
		.cos_out(cc), .sin_out(sc), .tag_out(axc)
	);

	// products stage: axis pairs and c/s terms
	logic v_s2;
	logic signed [15:0] c_s2, s_s2;
	logic signed [16:0] omc_s2;
	logic signed [31:0] xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2;
	logic signed [31:0] sx_s2, sy_s2, sz_s2;
	logic signed [15:0] cf, sf, rx, ry, rz;
	assign cf = fc ? -cc : cc;
	assign sf = fc ? -sc : sc;
	assign rx = axc[47:32];
	assign ry = axc[31:16];
	assign rz = axc[15:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= vc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= cf;
			omc_s2 <= 17'sd16384 - 17'(cf);
			xx_s2 <= rx * rx; yy_s2 <= ry * ry; zz_s2 <= rz * rz;
			xy_s2 <= rx * ry; xz_s2 <= rx * rz; yz_s2 <= ry * rz;
			sx_s2 <= rx * sf; sy_s2 <= ry * sf; sz_s2 <= rz * sf;
		end
	end

	// times (1 - c)
	logic v_s3;
	logic signed [47:0] cq_s3, pxx_s3, pyy_s3, pzz_s3, pxy_s3, pxz_s3, pyz_s3;
	logic signed [47:0] qx_s3, qy_s3, qz_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cq_s3 <= 48'(c_s2) <<< 28;
			pxx_s3 <= 48'(xx_s2) * 48'(omc_s2);
			pyy_s3 <= 48'(yy_s2) * 48'(omc_s2);
			pzz_s3 <= 48'(zz_s2) * 48'(omc_s2);
			pxy_s3 <= 48'(xy_s2) * 48'(omc_s2);
			pxz_s3 <= 48'(xz_s2) * 48'(omc_s2);
			pyz_s3 <= 48'(yz_s2) * 48'(omc_s2);
			qx_s3 <= 48'(sx_s2) <<< 14;
			qy_s3 <= 48'(sy_s2) <<< 14;
			qz_s3 <= 48'(sz_s2) <<< 14;
		end
	end

	// sum, round, saturate into output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.m00 <= sat_round(cq_s3 + pxx_s3);
			out_data.m01 <= sat_round(pxy_s3 - qz_s3);
			out_data.m02 <= sat_round(pxz_s3 + qy_s3);
			out_data.m10 <= sat_round(pxy_s3 + qz_s3);
			out_data.m11 <= sat_round(cq_s3 + pyy_s3);
			out_data.m12 <= sat_round(pyz_s3 - qx_s3);
			out_data.m20 <= sat_round(pxz_s3 - qy_s3);
			out_data.m21 <= sat_round(pyz_s3 + qx_s3);
			out_data.m22 <= sat_round(cq_s3 + pzz_s3);
		end
	end
endmodule

### rtl/aarm_cordic.sv
// one CORDIC micro-rotation per stage, stall-able
module aarm_cordic import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic flip_in,
	input  logic signed [15:0] ang_in,
	input  logic [47:0] tag_in,
	output logic vld_out,
	output logic flip_out,
	output logic signed [15:0] cos_out,
	output logic signed [15:0] sin_out,
	output logic [47:0] tag_out
);
	localparam int N = (CORDIC_STEPS > MaxSteps) ? MaxSteps :
		((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
	localparam longint Kn = GainInf + ((GainCorr + (64'd1 << (2 * N - 1))) >> (2 * N));

	logic signed [33:0] x_s [N+1];
	logic signed [33:0] y_s [N+1];
	logic signed [33:0] z_s [N+1];
	logic               v_s [N+1];
	logic               f_s [N+1];
	logic [47:0]        t_s [N+1];

	assign x_s[0] = 34'(Kn);
	assign y_s[0] = '0;
	assign z_s[0] = 34'(ang_in) <<< (FracBits - 13);
	assign v_s[0] = vld_in;
	assign f_s[0] = flip_in;
	assign t_s[0] = tag_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_lut(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_lut(i);
				end
				f_s[i+1] <= f_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	logic signed [33:0] xr, yr;
	assign xr = (x_s[N] + 34'sd32768) >>> 16;
	assign yr = (y_s[N] + 34'sd32768) >>> 16;
	assign vld_out = v_s[N];
	assign flip_out = f_s[N];
	assign cos_out = xr[15:0];
	assign sin_out = yr[15:0];
	assign tag_out = t_s[N];
endmodule

### rtl/aarm_checker.sv
`include "axis_angle_rotation_matrix_top_defines.svh"
module aarm_checker import aarm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	`AARM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled transfer changed")
	`AARM_ASSERT(a_ready, !out_valid |-> in_ready, "ready low with empty output")
	`AARM_ASSERT(a_diag_range, out_valid |-> (out_data.m00 <= 16'sd16384) && (out_data.m00 >= -16'sd16384), "m00 out of range")
	`AARM_ASSERT_RST(a_rst, !arst_n |-> !out_valid, "valid during reset")
endmodule

bind axis_angle_rotation_matrix_top aarm_checker u_aarm_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### tb/sv/tb_axis_angle_rotation_matrix_top.sv
`timescale 1ns / 100ps

module tb_axis_angle_rotation_matrix_top;
	import aarm_pkg::*;

	localparam int Steps = 14;
	localparam int Latency = Steps + 4;
	localparam int MaxReported = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	out_item_t matrix_q[$];
	int mismatches = 0;
	int unexpected = 0;
	bit hold_off = 1'b0;
	bit free_run = 1'b0;

	always #10 clk = ~clk;

	axis_angle_rotation_matrix_top #(.CORDIC_STEPS(Steps)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	function automatic longint floor_shift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic logic [15:0] round_clamp(longint v);
		longint r;
		r = floor_shift(v + (longint'(1) << 27), 28);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[15:0];
	endfunction

	// sine and cosine in Q1.14 by rotation-mode CORDIC with quadrant fold
	task automatic cordic_sin_cos(input longint a, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		flip = 1'b0;
		if (a > HalfPiQ13) begin
			a = a - PiQ13;
			flip = 1'b1;
		end else if (a < -HalfPiQ13) begin
			a = a + PiQ13;
			flip = 1'b1;
		end
		x = GainInf + ((GainCorr + (longint'(1) << (2 * Steps - 1))) >> (2 * Steps));
		y = 0;
		z = a * (longint'(1) << (FracBits - 13));
		for (int i = 0; i < Steps; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z = z - longint'(atan_lut(i));
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z = z + longint'(atan_lut(i));
			end
			x = nx;
		end
		c = floor_shift(x + (longint'(1) << 15), 16);
		s = floor_shift(y + (longint'(1) << 15), 16);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endtask

	task automatic predict_matrix(input in_item_t it, output out_item_t m);
		longint a, rx, ry, rz, c, s, omc, cq, sx, sy, sz;
		a = it.angle;
		rx = it.axis_x;
		ry = it.axis_y;
		rz = it.axis_z;
		cordic_sin_cos(a, c, s);
		omc = 16384 - c;
		cq = c * (longint'(1) << 28);
		sx = rx * s * 16384;
		sy = ry * s * 16384;
		sz = rz * s * 16384;
		m.m00 = round_clamp(cq + rx * rx * omc);
		m.m01 = round_clamp(rx * ry * omc - sz);
		m.m02 = round_clamp(rx * rz * omc + sy);
		m.m10 = round_clamp(ry * rx * omc + sz);
		m.m11 = round_clamp(cq + ry * ry * omc);
		m.m12 = round_clamp(ry * rz * omc - sx);
		m.m20 = round_clamp(rz * rx * omc - sy);
		m.m21 = round_clamp(rz * ry * omc + sx);
		m.m22 = round_clamp(cq + rz * rz * omc);
	endtask

	// one transfer on the input channel; valid stays up across back-to-back items when keep_valid is set
	task automatic send_rotation(input in_item_t it, input bit keep_valid = 1'b0);
		out_item_t m;
		predict_matrix(it, m);
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		matrix_q.push_back(m);
		@(negedge clk);
		if (!keep_valid)
			in_valid <= 1'b0;
	endtask

	task automatic send_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 1;
		repeat (gap) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom());
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic in_item_t rand_rotation();
		in_item_t it;
		it.angle = ($urandom_range(0, 7) == 0) ? 16'($urandom())
			: 16'($signed($urandom_range(0, 51472)) - 25736);
		it.axis_x = rand_axis();
		it.axis_y = rand_axis();
		it.axis_z = rand_axis();
		return it;
	endfunction

	task automatic wait_drained();
		while (matrix_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		logic signed [15:0] angles[12] = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd12869,
			-16'sd12869, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768, 16'sd6434,
			-16'sd1, 16'sd1};
		in_item_t it;
		foreach (angles[i]) begin
			it.angle = angles[i];
			it.axis_x = (i % 3 == 0) ? 16'sd16384 : 16'sd0;
			it.axis_y = (i % 3 == 1) ? -16'sd16384 : 16'sd0;
			it.axis_z = (i % 3 == 2) ? 16'sd16384 : 16'sd0;
			send_rotation(it, 1'b1);
		end
		// non-unit and out-of-range axes, saturating elements
		send_rotation('{16'sd8000, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b1);
		send_rotation('{-16'sd20000, -16'sd16384, 16'sd16384, -16'sd16384}, 1'b1);
		send_rotation('{16'sd25000, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b1);
		send_rotation('{-16'sd3000, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b1);
		send_rotation('{16'sd12000, 16'sd9459, 16'sd9459, 16'sd9459}, 1'b1);
		send_rotation('{16'shffff, 16'shffff, 16'shffff, 16'shffff});
		wait_drained();
	endtask

	task automatic test_random_bursts(input int n);
		int burst;
		int sent;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < n; k++, sent++)
				send_rotation(rand_rotation(), k != burst - 1 && sent != n - 1);
			send_gap();
		end
	endtask

	// receiver held off long enough for the pipeline to fill and block its input
	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int k = 0; k < 60; k++)
			send_rotation(rand_rotation(), k != 59);
		wait_drained();
	endtask

	task automatic test_full_rate();
		free_run = 1'b1;
		for (int k = 0; k < 200; k++)
			send_rotation(rand_rotation(), k != 199);
		wait_drained();
		free_run = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_off) begin
			out_ready <= 1'b0;
		end else if (free_run) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 9) < 7);
		end
	end

	// long receiver stall, counted in cycles here
	initial begin
		wait (hold_off);
		repeat (3 * Latency + 40) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (matrix_q.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= MaxReported)
					$display("unexpected result transfer %h", out_data);
			end else begin
				want = matrix_q.pop_front();
				if (want !== out_data) begin
					mismatches++;
					if (mismatches <= MaxReported)
						$display("matrix mismatch: expected %h got %h", want, out_data);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_axis_angle_rotation_matrix_top: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_bursts(600);
		wait_drained();
		test_backpressure();
		test_full_rate();
		test_random_bursts(570);
		wait_drained();
		repeat (Latency + 10) @(negedge clk);
		if (mismatches == 0 && matrix_q.size() == 0 && unexpected == 0) begin
			$display("tb_axis_angle_rotation_matrix_top: done, clean");
		end else begin
			$display("tb_axis_angle_rotation_matrix_top: done, errors");
		end
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_cordic.sv
rtl/axis_angle_rotation_matrix_top.sv
rtl/aarm_checker.sv
tb/sv/tb_axis_angle_rotation_matrix_top.sv
